// ===== hdl/edacc_pkg.sv =====
package edacc_pkg;

    // Channel count and configuration reset values
    localparam int CHANNELS_DEF = 4;

    localparam logic [15:0] TICKS_MAP_RST = 16'h4144;
    localparam logic [3:0]  POLARITY_RST  = 4'h0;
    localparam logic [15:0] L1_ON_RST     = 16'd35;
    localparam logic [15:0] L1_OFF_RST    = 16'd25;
    localparam logic [15:0] L2_ON_RST     = 16'd95;
    localparam logic [15:0] L2_OFF_RST    = 16'd70;
    localparam logic [7:0]  GAINS_RST     = 8'h42;
    localparam logic [15:0] IDLE_RST      = 16'd250;

    // Shared divider geometry: dividend, divisor and step counter widths
    localparam int DIV_NW = 41;
    localparam int DIV_DW = 17;
    localparam int DIV_SW = 6;

    // Significant dividend bits of each division
    localparam int NORM_BITS = 17;
    localparam int INST_BITS = 34;
    localparam int EMA_BITS  = 41;

    // Arithmetic constants
    localparam logic [16:0] TAU_MS      = 17'd90;
    localparam logic [17:0] SPEED_SCALE = 18'd256000;
    localparam logic [23:0] INST_MAX    = 24'hFFFF00;
    localparam logic [3:0]  MAX_GAIN    = 4'd8;

    // Speed levels
    localparam logic [1:0] LEVEL_ZERO = 2'd0;
    localparam logic [1:0] LEVEL_ONE  = 2'd1;
    localparam logic [1:0] LEVEL_TWO  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_SYNC  = 2'd0,
        FUNC_PLAIN = 2'd1,
        FUNC_ACCEL = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        REG_TICKS    = 3'd0,
        REG_POLARITY = 3'd1,
        REG_L1_ON    = 3'd2,
        REG_L1_OFF   = 3'd3,
        REG_L2_ON    = 3'd4,
        REG_L2_OFF   = 3'd5,
        REG_GAINS    = 3'd6,
        REG_IDLE     = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_NORM_WAIT,
        ST_TIME,
        ST_INST_GO,
        ST_INST_WAIT,
        ST_EMA_MUL,
        ST_EMA_GO,
        ST_EMA_WAIT,
        ST_LEVEL,
        ST_GAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_SW-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ===== hdl/edacc_div.sv =====
module edacc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  edacc_pkg::div_ctl_t            ctl,
    input  logic [edacc_pkg::DIV_NW-1:0]   dividend,
    input  logic [edacc_pkg::DIV_DW-1:0]   divisor,
    output edacc_pkg::div_sts_t            sts,
    output logic [edacc_pkg::DIV_NW-1:0]   quotient,
    output logic [edacc_pkg::DIV_DW-1:0]   remainder
);
    import edacc_pkg::*;

    logic [DIV_NW-1:0] num_reg, num_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_SW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW+1:0] diff;

    // One restoring step per cycle, dividend bits taken from the top
    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_NW-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = ctl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_NW-2:0], 1'b0};
            if (!diff[DIV_DW+1])
            begin
                rem_next = diff[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/encoder_detent_accelerator_core.sv =====
// Channel   Direction  Width                     Contents
// s_axis    in         tdata 48, tuser 4         raw_count, now_ms / func, channel
// m_axis    out        tdata 24                  detent_delta, speed_level
// cfg       in         addr 3, data 16           register index and value
//
// One word at a time: s_tready is high only while the sequencer is idle.
// Sync, unused codes and zero-change words skip the divider; a plain delta takes one division
// and an accelerated delta three, all on the shared restoring divider (17, 34 and 41 steps).
// A finished result waits in the output register while the next word is taken.
// Reset clears all channel state and loads the register defaults.
module encoder_detent_accelerator_core #(
    parameter int CHANNELS = edacc_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] raw_count, [47:16] now_ms
    input  logic [3:0]  s_tuser,   // [1:0] func, [3:2] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] detent_delta, [17:16] speed_level, rest zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import edacc_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers
    logic [15:0] ticks_map_reg;
    logic [3:0]  polarity_reg;
    logic [15:0] l1_on_reg, l1_off_reg, l2_on_reg, l2_off_reg;
    logic [7:0]  gains_reg;
    logic [15:0] idle_reg;

    // Channel state
    logic [15:0] plain_base_reg [CHANNELS];
    logic [15:0] accel_base_reg [CHANNELS];
    logic [4:0]  resid_reg      [CHANNELS];
    logic [31:0] stamp_reg      [CHANNELS];
    logic [23:0] ema_ch_reg     [CHANNELS];
    logic [1:0]  level_ch_reg   [CHANNELS];
    logic [1:0]  dir_ch_reg     [CHANNELS];

    // Sequencer and working registers
    state_t      state_reg, state_next;
    logic [1:0]  func_reg;
    logic [1:0]  ch_reg;
    logic [15:0] cur_reg;
    logic [31:0] now_reg;
    logic [16:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [3:0]  ticks_reg, ticks_next;
    logic [15:0] det_mag_reg, det_mag_next;
    logic [1:0]  lvl_reg, lvl_next;
    logic [15:0] dt_reg, dt_next;
    logic [23:0] ema_reg, ema_next;
    logic [23:0] inst_reg, inst_next;
    logic [33:0] prod_reg, prod_next;
    logic [30:0] prod_a_reg, prod_a_next;
    logic [39:0] prod_b_reg, prod_b_next;
    logic [1:0]  dir_reg, dir_next;
    logic [15:0] res_delta_reg, res_delta_next;
    logic [1:0]  res_level_reg, res_level_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_delta_reg;
    logic [1:0]  out_level_reg;
    logic        out_load;

    // Channel state write controls
    logic        wr_sync, wr_plain, wr_accel, wr_resid, wr_track;
    logic [4:0]  resid_wdata;

    // Divider hookup
    div_ctl_t          div_ctl;
    div_sts_t          div_sts;
    logic [DIV_NW-1:0] div_dividend, div_quotient;
    logic [DIV_DW-1:0] div_divisor, div_remainder;

    // Combinational helpers
    logic [CH_W-1:0]   ch_idx;
    logic              ch_ok;
    logic [15:0]       base_sel, rd16;
    logic [17:0]       raw_s, scaled;
    logic [3:0]        tick_nib;
    logic [16:0]       q17;
    logic [31:0]       dt32;
    logic [15:0]       idle_eff;
    logic              over;
    logic [1:0]        dir_w;
    logic [23:0]       spd;
    logic [23:0]       on1, off1, on2, off2;
    logic [1:0]        lvl_new;
    logic [3:0]        gain;
    logic [16:0]       det_s17;
    logic signed [21:0] gprod;
    logic [40:0]       ema_sum;

    function automatic logic [3:0] clamp_gain(input logic [3:0] g);
        logic [3:0] r;
        r = g;
        if (g == 4'd0)
            r = 4'd1;
        else if (g > MAX_GAIN)
            r = MAX_GAIN;
        return r;
    endfunction

    assign ch_idx  = CH_W'(ch_reg);
    assign ch_ok   = (32'(ch_reg) < CHANNELS);
    assign ema_sum = {10'b0, prod_a_reg} + {1'b0, prod_b_reg};

    edacc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .sts       (div_sts),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Divider operand selection by sequencer step
    always_comb
    begin
        case (state_reg)
            ST_INST_GO:
            begin
                div_dividend = {prod_reg, {(DIV_NW-INST_BITS){1'b0}}};
                div_divisor  = {1'b0, dt_reg};
            end
            ST_EMA_GO:
            begin
                div_dividend = ema_sum;
                div_divisor  = {1'b0, dt_reg} + TAU_MS;
            end
            default:
            begin
                div_dividend = {mag_next, {(DIV_NW-NORM_BITS){1'b0}}};
                div_divisor  = {13'b0, ticks_next};
            end
        endcase
    end

    // Sequencer: next state, working registers and state writes
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        ticks_next     = ticks_reg;
        det_mag_next   = det_mag_reg;
        lvl_next       = lvl_reg;
        dt_next        = dt_reg;
        ema_next       = ema_reg;
        inst_next      = inst_reg;
        prod_next      = prod_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        dir_next       = dir_reg;
        res_delta_next = res_delta_reg;
        res_level_next = res_level_reg;
        wr_sync        = 1'b0;
        wr_plain       = 1'b0;
        wr_accel       = 1'b0;
        wr_resid       = 1'b0;
        wr_track       = 1'b0;
        resid_wdata    = 5'd0;
        div_ctl.start  = 1'b0;
        div_ctl.steps  = DIV_SW'(NORM_BITS);
        out_load       = 1'b0;

        base_sel = (func_reg == FUNC_ACCEL) ? accel_base_reg[ch_idx] : plain_base_reg[ch_idx];
        rd16     = cur_reg - base_sel;
        raw_s    = {{2{rd16[15]}}, rd16};
        if (polarity_reg[ch_reg])
            raw_s = 18'd0 - raw_s;
        scaled   = raw_s + {{13{resid_reg[ch_idx][4]}}, resid_reg[ch_idx]};
        tick_nib = ticks_map_reg[{ch_reg, 2'b00} +: 4];
        q17      = div_quotient[16:0];

        dt32     = now_reg - stamp_reg[ch_idx];
        if (dt32 == 32'd0)
            dt32 = 32'd1;
        idle_eff = (idle_reg == 16'd0) ? 16'd1 : idle_reg;
        over     = dt32 > {16'b0, idle_eff};
        dir_w    = neg_reg ? DIR_NEG : DIR_POS;

        spd  = ema_reg;
        on1  = {l1_on_reg, 8'h00};
        off1 = {l1_off_reg, 8'h00};
        on2  = {l2_on_reg, 8'h00};
        off2 = {l2_off_reg, 8'h00};
        case (lvl_reg)
            LEVEL_ZERO: lvl_new = (spd >= on2) ? LEVEL_TWO :
                                  (spd >= on1) ? LEVEL_ONE : LEVEL_ZERO;
            LEVEL_ONE:  lvl_new = (spd >= on2) ? LEVEL_TWO :
                                  (spd < off1) ? LEVEL_ZERO : LEVEL_ONE;
            LEVEL_TWO:  lvl_new = (spd >= off2) ? LEVEL_TWO :
                                  (spd < off1) ? LEVEL_ZERO : LEVEL_ONE;
            default:    lvl_new = LEVEL_ZERO;
        endcase

        case (lvl_reg)
            LEVEL_TWO: gain = clamp_gain(gains_reg[7:4]);
            LEVEL_ONE: gain = clamp_gain(gains_reg[3:0]);
            default:   gain = 4'd1;
        endcase
        det_s17 = neg_reg ? (17'd0 - {1'b0, det_mag_reg}) : {1'b0, det_mag_reg};
        gprod   = $signed(det_s17) * $signed({1'b0, gain});

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_PREP;
            end

            // Decode the word, take the raw change and start the tick division
            ST_PREP:
            begin
                res_delta_next = 16'd0;
                res_level_next = LEVEL_ZERO;
                lvl_next       = level_ch_reg[ch_idx];
                neg_next       = scaled[17];
                mag_next       = scaled[17] ? 17'(18'd0 - scaled) : scaled[16:0];
                ticks_next     = (tick_nib == 4'd0) ? 4'd1 : tick_nib;
                state_next     = ST_OUT;
                if (ch_ok)
                begin
                    case (func_reg)
                        FUNC_SYNC:
                        begin
                            wr_sync = 1'b1;
                        end
                        FUNC_PLAIN, FUNC_ACCEL:
                        begin
                            res_level_next = level_ch_reg[ch_idx];
                            // An accelerated word with no change leaves both baselines
                            wr_plain = (func_reg == FUNC_PLAIN) || (rd16 != 16'd0);
                            if (func_reg == FUNC_ACCEL)
                                wr_accel = (rd16 != 16'd0);
                            if (rd16 != 16'd0)
                            begin
                                if (scaled == 18'd0)
                                begin
                                    wr_resid    = 1'b1;
                                    resid_wdata = 5'd0;
                                end
                                else
                                begin
                                    div_ctl.start = 1'b1;
                                    div_ctl.steps = DIV_SW'(NORM_BITS);
                                    state_next    = ST_NORM_WAIT;
                                end
                            end
                        end
                        default:
                        begin
                            res_level_next = LEVEL_ZERO;
                        end
                    endcase
                end
            end

            // Truncate, force small sums to one detent, carry the residual
            ST_NORM_WAIT:
            begin
                if (div_sts.done)
                begin
                    wr_resid = 1'b1;
                    if (q17 == 17'd0)
                    begin
                        det_mag_next = 16'd1;
                        resid_wdata  = neg_reg ? ({1'b0, ticks_reg} - {1'b0, mag_reg[3:0]})
                                               : ({1'b0, mag_reg[3:0]} - {1'b0, ticks_reg});
                    end
                    else
                    begin
                        resid_wdata = neg_reg ? (5'd0 - {1'b0, div_remainder[3:0]})
                                              : {1'b0, div_remainder[3:0]};
                        if (!neg_reg && q17 > 17'd32767)
                            det_mag_next = 16'h7FFF;
                        else if (neg_reg && q17 > 17'd32768)
                            det_mag_next = 16'h8000;
                        else
                            det_mag_next = q17[15:0];
                    end
                    if (func_reg == FUNC_ACCEL)
                    begin
                        state_next = ST_TIME;
                    end
                    else
                    begin
                        res_delta_next = neg_reg ? (16'd0 - det_mag_next) : det_mag_next;
                        state_next     = ST_OUT;
                    end
                end
            end

            // Elapsed time, idle and reversal clears, inst speed numerator
            ST_TIME:
            begin
                dt_next   = over ? idle_eff : dt32[15:0];
                dir_next  = dir_w;
                if (over || dir_w != dir_ch_reg[ch_idx])
                begin
                    ema_next = 24'd0;
                    lvl_next = LEVEL_ZERO;
                end
                else
                begin
                    ema_next = ema_ch_reg[ch_idx];
                    lvl_next = level_ch_reg[ch_idx];
                end
                prod_next  = 34'(det_mag_reg) * 34'(SPEED_SCALE);
                state_next = ST_INST_GO;
            end

            ST_INST_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = DIV_SW'(INST_BITS);
                state_next    = ST_INST_WAIT;
            end

            // Saturate the instantaneous speed
            ST_INST_WAIT:
            begin
                if (div_sts.done)
                begin
                    if (div_quotient[33:0] > 34'(INST_MAX))
                        inst_next = INST_MAX;
                    else
                        inst_next = div_quotient[23:0];
                    state_next = ST_EMA_MUL;
                end
            end

            ST_EMA_MUL:
            begin
                prod_a_next = 31'(ema_reg) * 31'(TAU_MS);
                prod_b_next = 40'(inst_reg) * 40'(dt_reg);
                state_next  = ST_EMA_GO;
            end

            ST_EMA_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = DIV_SW'(EMA_BITS);
                state_next    = ST_EMA_WAIT;
            end

            ST_EMA_WAIT:
            begin
                if (div_sts.done)
                begin
                    ema_next   = div_quotient[23:0];
                    state_next = ST_LEVEL;
                end
            end

            // Hysteresis step and channel tracking update
            ST_LEVEL:
            begin
                lvl_next   = lvl_new;
                wr_track   = 1'b1;
                state_next = ST_GAIN;
            end

            // Apply level gain and saturate
            ST_GAIN:
            begin
                if (gprod > 22'sd32767)
                    res_delta_next = 16'h7FFF;
                else if (gprod < -22'sd32768)
                    res_delta_next = 16'h8000;
                else
                    res_delta_next = gprod[15:0];
                res_level_next = lvl_reg;
                state_next     = ST_OUT;
            end

            // Hand the result to the output register once it is free
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Sequencer and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_map_reg <= TICKS_MAP_RST;
            polarity_reg  <= POLARITY_RST;
            l1_on_reg     <= L1_ON_RST;
            l1_off_reg    <= L1_OFF_RST;
            l2_on_reg     <= L2_ON_RST;
            l2_off_reg    <= L2_OFF_RST;
            gains_reg     <= GAINS_RST;
            idle_reg      <= IDLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_TICKS:    ticks_map_reg <= cfg_data;
                REG_POLARITY: polarity_reg  <= cfg_data[3:0];
                REG_L1_ON:    l1_on_reg     <= cfg_data;
                REG_L1_OFF:   l1_off_reg    <= cfg_data;
                REG_L2_ON:    l2_on_reg     <= cfg_data;
                REG_L2_OFF:   l2_off_reg    <= cfg_data;
                REG_GAINS:    gains_reg     <= cfg_data[7:0];
                REG_IDLE:     idle_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                plain_base_reg[i] <= '0;
                accel_base_reg[i] <= '0;
                resid_reg[i]      <= '0;
                stamp_reg[i]      <= '0;
                ema_ch_reg[i]     <= '0;
                level_ch_reg[i]   <= LEVEL_ZERO;
                dir_ch_reg[i]     <= DIR_NONE;
            end
        end
        else
        begin
            if (wr_sync)
            begin
                plain_base_reg[ch_idx] <= cur_reg;
                accel_base_reg[ch_idx] <= cur_reg;
                resid_reg[ch_idx]      <= '0;
                stamp_reg[ch_idx]      <= now_reg;
                ema_ch_reg[ch_idx]     <= '0;
                level_ch_reg[ch_idx]   <= LEVEL_ZERO;
                dir_ch_reg[ch_idx]     <= DIR_NONE;
            end
            if (wr_plain)
                plain_base_reg[ch_idx] <= cur_reg;
            if (wr_accel)
                accel_base_reg[ch_idx] <= cur_reg;
            if (wr_resid)
                resid_reg[ch_idx] <= resid_wdata;
            if (wr_track)
            begin
                stamp_reg[ch_idx]    <= now_reg;
                ema_ch_reg[ch_idx]   <= ema_reg;
                level_ch_reg[ch_idx] <= lvl_new;
                dir_ch_reg[ch_idx]   <= dir_reg;
            end
        end
    end

    // Input capture and working datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            func_reg <= s_tuser[1:0];
            ch_reg   <= s_tuser[3:2];
            cur_reg  <= s_tdata[15:0];
            now_reg  <= s_tdata[47:16];
        end
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        ticks_reg     <= ticks_next;
        det_mag_reg   <= det_mag_next;
        lvl_reg       <= lvl_next;
        dt_reg        <= dt_next;
        ema_reg       <= ema_next;
        inst_reg      <= inst_next;
        prod_reg      <= prod_next;
        prod_a_reg    <= prod_a_next;
        prod_b_reg    <= prod_b_next;
        dir_reg       <= dir_next;
        res_delta_reg <= res_delta_next;
        res_level_reg <= res_level_next;
        if (out_load)
        begin
            out_delta_reg <= res_delta_reg;
            out_level_reg <= res_level_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_level_reg, out_delta_reg};

endmodule

// ===== hdl/edacc_chk.sv =====
module edacc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One word in flight: busy right after an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // A fresh result leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while sequencer still busy");

    // Level never shows the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[17:16] != 2'd3)
        else $error("invalid speed level");

endmodule

bind encoder_detent_accelerator_core edacc_chk u_edacc_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
